// ===== design/srmv_pkg.sv =====
// ----------------------------------------------------------------------------
// srmv_pkg
// Types, constants and codes shared by the sparse row mean/variance block.
// ----------------------------------------------------------------------------
package srmv_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int ADDR_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_W     = 10;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 24;
  localparam int SUM_W     = 64;
  localparam int VAR_W     = 63;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  // one-pass total fits in 98 signed bits; divider runs over this width
  localparam int T_W       = 100;
  localparam int DCNT_W    = $clog2(T_W + 1);
  localparam int IN_W      = 48;
  localparam int OUT_W     = 112;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENTRY  = 2'd0,
    KIND_CENTER = 2'd1,
    KIND_EMIT   = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_COLS        = 2'd0,
    CFG_NA_RM           = 2'd1,
    CFG_CENTER_PROVIDED = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC,
    ST_ENT_WR,
    ST_EM_LD,
    ST_MDIV_GO,
    ST_MDIV_WAIT,
    ST_MEAN,
    ST_MUL,
    ST_VDIV_GO,
    ST_VDIV_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sum_sq;
    logic [CNT_W-1:0] st_cnt;
    logic [CNT_W-1:0] na_cnt;
    logic             na_seen;
  } stat_t;

  typedef struct packed {
    logic              clr_wr;
    logic [ADDR_W-1:0] clr_addr;
    logic              in_accept;
    logic              rd;
    logic              ent_wr;
    logic              cen_wr;
    logic              em_ld;
    logic              div_start;
    logic              div_sel;
    logic              mean_ld;
    logic              mul_en;
    logic [2:0]        mul_k;
    logic              out_ld;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              row_ok;
    logic              mean_undef;
    logic              var_ok;
    logic              div_busy;
    logic              out_busy;
  } status_t;

endpackage

// ===== design/srmv_div.sv =====
// ----------------------------------------------------------------------------
// srmv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srmv_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [srmv_pkg::T_W-1:0]  dividend_i,
  input  logic [srmv_pkg::CNT_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [srmv_pkg::T_W-1:0]  quotient_o
);
  import srmv_pkg::*;

  logic              busy_q, busy_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [T_W-1:0]    quo_q, quo_d;
  logic [CNT_W:0]    shifted;
  logic [CNT_W+1:0]  diff;

  always_comb begin
    shifted = {rem_q, quo_q[T_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(T_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (!diff[CNT_W+1]) begin
        rem_d = diff[CNT_W-1:0];
        quo_d = {quo_q[T_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[CNT_W-1:0];
        quo_d = {quo_q[T_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/srmv_ctrl.sv =====
// ----------------------------------------------------------------------------
// srmv_ctrl
// Controller: clearing pass, item dispatch and emit sequencing.
// ----------------------------------------------------------------------------
module srmv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srmv_pkg::status_t stat_i,
  output srmv_pkg::cmd_t    cmd_o
);
  import srmv_pkg::*;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [2:0]        k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    k_d            = k_q;
    cmd_o          = '0;
    cmd_o.clr_addr = clr_q;
    cmd_o.mul_k    = k_q;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        clr_d        = clr_q + 1'b1;
        if (clr_q == ADDR_W'(MAX_ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_accept = 1'b1;
          state_d         = ST_DEC;
        end
      end
      ST_DEC: begin
        if (!stat_i.row_ok) begin
          state_d = ST_IDLE;
        end else begin
          case (stat_i.kind)
            KIND_ENTRY: begin
              cmd_o.rd = 1'b1;
              state_d  = ST_ENT_WR;
            end
            KIND_CENTER: begin
              cmd_o.cen_wr = 1'b1;
              state_d      = ST_IDLE;
            end
            KIND_EMIT: begin
              cmd_o.rd = 1'b1;
              state_d  = ST_EM_LD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ENT_WR: begin
        cmd_o.ent_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_EM_LD: begin
        cmd_o.em_ld = 1'b1;
        state_d     = ST_MDIV_GO;
      end
      ST_MDIV_GO: begin
        if (stat_i.mean_undef) begin
          state_d = ST_MEAN;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_MDIV_WAIT;
        end
      end
      ST_MDIV_WAIT: begin
        if (!stat_i.div_busy) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN: begin
        cmd_o.mean_ld = 1'b1;
        k_d           = '0;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        k_d          = k_q + 1'b1;
        if (k_q == 3'd5) begin
          state_d = ST_VDIV_GO;
        end
      end
      ST_VDIV_GO: begin
        if (stat_i.var_ok) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          state_d         = ST_VDIV_WAIT;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_VDIV_WAIT: begin
        if (!stat_i.div_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/srmv_dp.sv =====
// ----------------------------------------------------------------------------
// srmv_dp
// Datapath: row statistics memory, accumulate, one-pass variance, result.
// ----------------------------------------------------------------------------
module srmv_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [srmv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [srmv_pkg::CNT_W-1:0]   cfg_data_i,
  input  logic [srmv_pkg::KIND_W-1:0]  in_kind_i,
  input  logic [srmv_pkg::ROW_W-1:0]   in_row_i,
  input  logic [srmv_pkg::VAL_W-1:0]   in_value_i,
  input  logic                         in_na_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [srmv_pkg::ROW_W-1:0]   out_row_o,
  output logic [srmv_pkg::VAL_W-1:0]   out_mean_o,
  output logic [srmv_pkg::VAR_W-1:0]   out_var_o,
  output logic                         out_mean_undef_o,
  output logic                         out_var_undef_o,
  output logic                         out_row_na_o,
  input  srmv_pkg::cmd_t               cmd_i,
  output srmv_pkg::status_t            stat_o
);
  import srmv_pkg::*;

  // configuration
  logic [CNT_W-1:0] num_cols_q;
  logic             na_rm_q;
  logic             cen_prov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= CNT_W'(1);
      na_rm_q    <= 1'b0;
      cen_prov_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NUM_COLS:        num_cols_q <= cfg_data_i;
        CFG_NA_RM:           na_rm_q    <= cfg_data_i[0];
        CFG_CENTER_PROVIDED: cen_prov_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // item latch
  logic [KIND_W-1:0] kind_q;
  logic [ROW_W-1:0]  row_q;
  logic [VAL_W-1:0]  val_q;
  logic              na_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_accept) begin
      kind_q <= in_kind_i;
      row_q  <= in_row_i;
      val_q  <= in_value_i;
      na_q   <= in_na_i;
    end
  end

  logic [ADDR_W-1:0] addr;
  assign addr = ADDR_W'(row_q);

  // memories
  stat_t            stat_mem [MAX_ROWS];
  logic [VAL_W-1:0] cen_mem  [MAX_ROWS];
  stat_t            rd_q;
  logic [VAL_W-1:0] cen_rd_q;
  stat_t            upd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      stat_mem[cmd_i.clr_addr] <= '0;
      cen_mem[cmd_i.clr_addr]  <= '0;
    end else begin
      if (cmd_i.ent_wr) begin
        stat_mem[addr] <= upd;
      end else if (cmd_i.em_ld) begin
        stat_mem[addr] <= '0;
      end
      if (cmd_i.cen_wr) begin
        cen_mem[addr] <= val_q;
      end
    end
    if (cmd_i.rd) begin
      rd_q     <= stat_mem[addr];
      cen_rd_q <= cen_mem[addr];
    end
  end

  // entry accumulate
  logic [VAL_W-1:0]   vmag;
  logic [SUM_W-1:0]   sq_q;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W:0]     sq_ext;

  assign vmag = val_q[VAL_W-1] ? (~val_q + 1'b1) : val_q;

  always_ff @(posedge clk_i) begin
    sq_q <= vmag * vmag;
  end

  always_comb begin
    sum_ext = {rd_q.sum[SUM_W-1], rd_q.sum} + {{(SUM_W-VAL_W+1){val_q[VAL_W-1]}}, val_q};
    sq_ext  = {1'b0, rd_q.sum_sq} + {1'b0, sq_q};
    upd     = rd_q;
    if (rd_q.st_cnt != CNT_MAX) begin
      upd.st_cnt = rd_q.st_cnt + 1'b1;
    end
    if (na_q) begin
      if (na_rm_q) begin
        if (rd_q.na_cnt != CNT_MAX) begin
          upd.na_cnt = rd_q.na_cnt + 1'b1;
        end
      end else begin
        upd.na_seen = 1'b1;
      end
    end else begin
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
        upd.sum = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        upd.sum = sum_ext[SUM_W-1:0];
      end
      upd.sum_sq = sq_ext[SUM_W] ? '1 : sq_ext[SUM_W-1:0];
    end
  end

  // emit working registers
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] s2_q;
  logic [CNT_W:0]   d_q;
  logic             na_seen_q;
  logic [VAL_W-1:0] center_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.em_ld) begin
      sum_q     <= rd_q.sum;
      s2_q      <= rd_q.sum_sq;
      d_q       <= {1'b0, num_cols_q} - {1'b0, rd_q.na_cnt};
      na_seen_q <= rd_q.na_seen;
      center_q  <= cen_rd_q;
    end
  end

  logic             mean_undef;
  logic             var_undef;
  logic [CNT_W:0]   d_neg;
  logic [CNT_W:0]   d_m1;
  logic [CNT_W-1:0] dmag;
  logic [SUM_W-1:0] smag;

  assign mean_undef = (d_q == '0);
  assign var_undef  = d_q[CNT_W] || (d_q[CNT_W-1:1] == '0);
  assign d_neg      = ~d_q + 1'b1;
  assign d_m1       = d_q - 1'b1;
  assign dmag       = d_q[CNT_W] ? d_neg[CNT_W-1:0] : d_q[CNT_W-1:0];
  assign smag       = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

  // shared divider
  logic [T_W-1:0] t_q;
  logic [T_W-1:0] div_a;
  logic [CNT_W-1:0] div_b;
  logic [T_W-1:0] quo;
  logic           div_busy;

  assign div_a = cmd_i.div_sel ? t_q : {{(T_W-SUM_W){1'b0}}, smag};
  assign div_b = cmd_i.div_sel ? d_m1[CNT_W-1:0] : dmag;

  srmv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // mean and center
  logic             m_neg;
  logic             sat_n;
  logic             sat_p;
  logic [VAL_W-1:0] mean_v;
  logic [VAL_W-1:0] c_q;

  always_comb begin
    m_neg = sum_q[SUM_W-1] ^ d_q[CNT_W];
    sat_n = (|quo[T_W-1:VAL_W]) || (quo[VAL_W-1] && (|quo[VAL_W-2:0]));
    sat_p = |quo[T_W-1:VAL_W-1];
    if (mean_undef) begin
      mean_v = '0;
    end else if (m_neg) begin
      mean_v = sat_n ? {1'b1, {(VAL_W-1){1'b0}}} : (~quo[VAL_W-1:0] + 1'b1);
    end else begin
      mean_v = sat_p ? {1'b0, {(VAL_W-1){1'b1}}} : {1'b0, quo[VAL_W-2:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_ld) begin
      c_q <= cen_prov_q ? center_q : mean_v;
    end
  end

  // one-pass total: S2 - 2*c*S1 + d*c*c from 32x32 partial products
  logic [VAL_W-1:0] cmag;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [SUM_W-1:0] p_q;
  logic [SUM_W-1:0] cc_q;
  logic [T_W-1:0]   pe;
  logic             s1_neg;

  assign cmag   = c_q[VAL_W-1] ? (~c_q + 1'b1) : c_q;
  assign pe     = {{(T_W-SUM_W){1'b0}}, p_q};
  assign s1_neg = c_q[VAL_W-1] ^ sum_q[SUM_W-1];

  always_comb begin
    case (cmd_i.mul_k)
      3'd0: begin
        mul_a = cmag;
        mul_b = cmag;
      end
      3'd1: begin
        mul_a = cmag;
        mul_b = smag[31:0];
      end
      3'd2: begin
        mul_a = cmag;
        mul_b = smag[63:32];
      end
      3'd3: begin
        mul_a = {{(32-CNT_W){1'b0}}, dmag};
        mul_b = cc_q[31:0];
      end
      3'd4: begin
        mul_a = {{(32-CNT_W){1'b0}}, dmag};
        mul_b = cc_q[63:32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_k)
        3'd0: t_q  <= {{(T_W-SUM_W){1'b0}}, s2_q};
        3'd1: cc_q <= p_q;
        3'd2: t_q  <= s1_neg ? (t_q + (pe << 1)) : (t_q - (pe << 1));
        3'd3: t_q  <= s1_neg ? (t_q + (pe << 33)) : (t_q - (pe << 33));
        3'd4: t_q  <= d_q[CNT_W] ? (t_q - pe) : (t_q + pe);
        3'd5: t_q  <= d_q[CNT_W] ? (t_q - (pe << 32)) : (t_q + (pe << 32));
        default: ;
      endcase
    end
  end

  logic             var_ok;
  logic [VAR_W-1:0] var_v;

  assign var_ok = !var_undef && !na_seen_q && !t_q[T_W-1];
  assign var_v  = !var_ok ? '0 :
                  (|quo[T_W-1:VAR_W+16]) ? '1 : quo[VAR_W+15:16];

  // result register
  logic             out_valid_q;
  logic [ROW_W-1:0] out_row_q;
  logic [VAL_W-1:0] out_mean_q;
  logic [VAR_W-1:0] out_var_q;
  logic             out_mu_q;
  logic             out_vu_q;
  logic             out_na_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_row_q  <= row_q;
      out_mean_q <= (na_seen_q && !cen_prov_q) ? '0 : c_q;
      out_var_q  <= var_v;
      out_mu_q   <= mean_undef;
      out_vu_q   <= var_undef;
      out_na_q   <= na_seen_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_row_o        = out_row_q;
  assign out_mean_o       = out_mean_q;
  assign out_var_o        = out_var_q;
  assign out_mean_undef_o = out_mu_q;
  assign out_var_undef_o  = out_vu_q;
  assign out_row_na_o     = out_na_q;

  always_comb begin
    stat_o            = '0;
    stat_o.kind       = kind_q;
    stat_o.row_ok     = ({22'd0, row_q} < 32'(MAX_ROWS));
    stat_o.mean_undef = mean_undef;
    stat_o.var_ok     = var_ok;
    stat_o.div_busy   = div_busy;
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end

endmodule

// ===== design/sparse_row_mean_variance.sv =====
// Throughput: one item at a time, so no item is accepted until the last one is
// through. Entries do a row memory read-modify-write; emits run a bit-serial
// mean division (skipped when the mean is undefined) and a bit-serial variance
// division (skipped when the variance is undefined, the row is NA or the total
// is negative). A pending result stalls an emit.
// Reset: asynchronous, active low; a clearing pass over all 1024 rows zeroes them.
// ----------------------------------------------------------------------------
// sparse_row_mean_variance
// Per-row mean and variance of a streamed sparse matrix.
// ----------------------------------------------------------------------------
module sparse_row_mean_variance (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [srmv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [srmv_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // row_index[9:0], entry_value[41:10], entry_is_na[42], zero fill
  input  logic [srmv_pkg::IN_W-1:0]      s_axis_tdata,
  // kind[1:0]
  input  logic [srmv_pkg::KIND_W-1:0]    s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_row[9:0], row_mean[41:10], row_variance[104:42], mean_undefined[105],
  // variance_undefined[106], row_is_na[107], zero fill
  output logic [srmv_pkg::OUT_W-1:0]     m_axis_tdata
);
  import srmv_pkg::*;

  cmd_t             cmd;
  status_t          stat;
  logic [ROW_W-1:0] o_row;
  logic [VAL_W-1:0] o_mean;
  logic [VAR_W-1:0] o_var;
  logic             o_mu;
  logic             o_vu;
  logic             o_na;

  srmv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  srmv_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_kind_i        (s_axis_tuser),
    .in_row_i         (s_axis_tdata[9:0]),
    .in_value_i       (s_axis_tdata[41:10]),
    .in_na_i          (s_axis_tdata[42]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_row_o        (o_row),
    .out_mean_o       (o_mean),
    .out_var_o        (o_var),
    .out_mean_undef_o (o_mu),
    .out_var_undef_o  (o_vu),
    .out_row_na_o     (o_na),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

  assign m_axis_tdata = {4'd0, o_na, o_vu, o_mu, o_var, o_mean, o_row};

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while previous item still in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> !stat.out_busy)
    else $error("pending result overwritten");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> stat.div_busy)
    else $error("divider did not start");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sparse_row_mean_variance: directed and random
// entry, center and emit transactions. A per-row predictor gives the expected
// mean, variance and flags. Random idling runs on both stream sides, and one
// long receiver hold-off fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import srmv_pkg::*;

  localparam logic [CNT_W-1:0] COLS_MAX = '1;

  typedef struct {
    logic [ROW_W-1:0]  row;
    logic [VAL_W-1:0]  mean;
    logic [VAR_W-1:0]  variance;
    logic              mean_undef;
    logic              var_undef;
    logic              row_na;
  } row_stats_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CNT_W-1:0]      cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic [KIND_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;

  sparse_row_mean_variance uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [SUM_W-1:0] acc_sum [MAX_ROWS];
  logic [SUM_W-1:0]        acc_sq [MAX_ROWS];
  logic [CNT_W-1:0]        acc_cnt [MAX_ROWS];
  logic [CNT_W-1:0]        acc_na [MAX_ROWS];
  logic                    acc_na_seen [MAX_ROWS];
  logic signed [VAL_W-1:0] center_mem [MAX_ROWS];
  logic [CNT_W-1:0]        cols_q = 1;
  logic                    na_rm_q = 1'b0;
  logic                    cp_q = 1'b0;

  row_stats_t stats_q[$];
  int         errors = 0;
  int         snd_idle = 0;
  int         rcv_idle = 0;
  int         hold_cycles = 0;

  initial begin
    for (int r = 0; r < MAX_ROWS; r++) begin
      acc_sum[r] = '0; acc_sq[r] = '0; acc_cnt[r] = '0; acc_na[r] = '0;
      acc_na_seen[r] = 1'b0; center_mem[r] = '0;
    end
  end

  task automatic predict_item(logic [KIND_W-1:0] kind, logic [ROW_W-1:0] row,
                              logic signed [VAL_W-1:0] val, logic na);
    logic signed [SUM_W:0]  s;
    logic [SUM_W:0]         sq;
    logic [SUM_W-1:0]       mag, q64;
    longint                 d, dv, mean, c;
    logic signed [129:0]    t, cw, sw;
    logic [129:0]           qv;
    row_stats_t             e;
    if (kind == KIND_ENTRY) begin
      if (acc_cnt[row] != COLS_MAX) acc_cnt[row]++;
      if (na) begin
        if (na_rm_q) begin
          if (acc_na[row] != COLS_MAX) acc_na[row]++;
        end else begin
          acc_na_seen[row] = 1'b1;
        end
      end else begin
        s = acc_sum[row] + val;
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) acc_sum[row] = 64'h7FFF_FFFF_FFFF_FFFF;
        else if (s < -65'sh0_8000_0000_0000_0000) acc_sum[row] = 64'h8000_0000_0000_0000;
        else acc_sum[row] = s[SUM_W-1:0];
        mag = (val < 0) ? -longint'(val) : longint'(val);
        sq = acc_sq[row] + mag * mag;
        acc_sq[row] = sq[SUM_W] ? '1 : sq[SUM_W-1:0];
      end
    end else if (kind == KIND_CENTER) begin
      center_mem[row] = val;
    end else if (kind == KIND_EMIT) begin
      d = longint'(cols_q) - longint'(acc_na[row]);
      dv = d - 1;
      mean = 0;
      if (d != 0) begin
        mag = acc_sum[row][SUM_W-1] ? -acc_sum[row] : acc_sum[row];
        q64 = mag / ((d < 0) ? -d : d);
        if (acc_sum[row][SUM_W-1] != (d < 0)) begin
          if (q64 > 64'h8000_0000) q64 = 64'h8000_0000;
          mean = -longint'(q64);
        end else begin
          if (q64 > 64'h7FFF_FFFF) q64 = 64'h7FFF_FFFF;
          mean = longint'(q64);
        end
      end
      c = cp_q ? longint'(center_mem[row]) : mean;
      e.variance = '0;
      if (dv > 0 && !acc_na_seen[row]) begin
        cw = c;
        sw = acc_sum[row];
        t = $signed({66'b0, acc_sq[row]}) - 2 * cw * sw + 130'(d) * cw * cw;
        if (t >= 0) begin
          qv = $unsigned(t) / 130'(dv);
          if (qv[129:79] != '0) e.variance = '1;
          else e.variance = qv[78:16];
        end
      end
      e.row = row;
      e.mean = (acc_na_seen[row] && !cp_q) ? '0 : c[31:0];
      e.mean_undef = (d == 0);
      e.var_undef = (dv <= 0);
      e.row_na = acc_na_seen[row];
      stats_q.push_back(e);
      acc_sum[row] = '0; acc_sq[row] = '0; acc_cnt[row] = '0; acc_na[row] = '0;
      acc_na_seen[row] = 1'b0;
    end
  endtask

  task automatic send_item(logic [KIND_W-1:0] kind, logic [ROW_W-1:0] row,
                           logic [VAL_W-1:0] val, logic na);
    if ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = kind;
    s_axis_tdata = {5'b0, na, val, row};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(kind, row, val, na);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    wait (stats_q.size() == 0);
    repeat (250) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CNT_W-1:0] data);
    drain();
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_NUM_COLS: cols_q = data;
      CFG_NA_RM: na_rm_q = data[0];
      default: cp_q = data[0];
    endcase
  endtask

  task automatic set_config(logic [CNT_W-1:0] cols, logic na_rm, logic cp);
    write_reg(CFG_NUM_COLS, cols);
    write_reg(CFG_NA_RM, {23'b0, na_rm});
    write_reg(CFG_CENTER_PROVIDED, {23'b0, cp});
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
    endcase
  endfunction

  // receiver: random stalls and a counted hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk_i) begin
    row_stats_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (stats_q.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = stats_q.pop_front();
        if (m_axis_tdata[9:0] !== e.row) begin
          $display("%0t: out_row exp %h got %h", $time, e.row, m_axis_tdata[9:0]);
          errors++;
        end
        if (m_axis_tdata[41:10] !== e.mean) begin
          $display("%0t: row_mean exp %h got %h", $time, e.mean, m_axis_tdata[41:10]);
          errors++;
        end
        if (m_axis_tdata[104:42] !== e.variance) begin
          $display("%0t: row_variance exp %h got %h", $time, e.variance,
                   m_axis_tdata[104:42]);
          errors++;
        end
        if (m_axis_tdata[105] !== e.mean_undef) begin
          $display("%0t: mean_undefined exp %b got %b", $time, e.mean_undef,
                   m_axis_tdata[105]);
          errors++;
        end
        if (m_axis_tdata[106] !== e.var_undef) begin
          $display("%0t: variance_undefined exp %b got %b", $time, e.var_undef,
                   m_axis_tdata[106]);
          errors++;
        end
        if (m_axis_tdata[107] !== e.row_na) begin
          $display("%0t: row_is_na exp %b got %b", $time, e.row_na, m_axis_tdata[107]);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    set_config(4, 1'b0, 1'b0);
    send_item(KIND_ENTRY, 10'd0, 32'h7FFF_FFFF, 1'b0);
    send_item(KIND_ENTRY, 10'd0, 32'h8000_0000, 1'b0);
    send_item(KIND_ENTRY, 10'd0, 32'h0001_0000, 1'b0);
    send_item(KIND_EMIT, 10'd0, '0, 1'b0);
    send_item(KIND_ENTRY, 10'd1023, 32'h0002_0000, 1'b0);
    send_item(KIND_ENTRY, 10'd1023, 32'h0000_0000, 1'b1);
    send_item(KIND_EMIT, 10'd1023, '0, 1'b0);
    send_item(3, 10'd5, 32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 5; i++) send_item(KIND_ENTRY, 10'd2, 32'h8000_0000, 1'b0);
    send_item(KIND_EMIT, 10'd2, '0, 1'b0);
    set_config(1, 1'b1, 1'b1);
    send_item(KIND_CENTER, 10'd3, 32'hFFFE_8000, 1'b0);
    send_item(KIND_ENTRY, 10'd3, 32'h0003_0000, 1'b1);
    send_item(KIND_ENTRY, 10'd3, 32'h0003_0000, 1'b1);
    send_item(KIND_EMIT, 10'd3, '0, 1'b0);
    send_item(KIND_EMIT, 10'd4, '0, 1'b0);
    set_config(0, 1'b0, 1'b1);
    send_item(KIND_ENTRY, 10'd3, 32'h0000_8000, 1'b1);
    send_item(KIND_EMIT, 10'd3, '0, 1'b0);
    set_config(COLS_MAX, 1'b0, 1'b0);
    send_item(KIND_ENTRY, 10'd6, 32'h7FFF_FFFF, 1'b0);
    send_item(KIND_EMIT, 10'd6, '0, 1'b0);
  endtask

  task automatic test_random(int n);
    int k;
    logic [ROW_W-1:0] row;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      row = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(7));
      if (k < 2) send_item(3, row, $urandom, 1'($urandom));
      else if (k < 8) send_item(KIND_CENTER, row, pick_value(), 1'($urandom));
      else if (k < 24) send_item(KIND_EMIT, row, $urandom, 1'($urandom));
      else send_item(KIND_ENTRY, row, pick_value(), $urandom_range(9) == 0);
    end
  endtask

  task automatic test_holdoff();
    hold_cycles = 3000;
    for (int i = 0; i < 20; i++) begin
      send_item(KIND_ENTRY, 10'(i % 4), pick_value(), 1'b0);
      send_item(KIND_EMIT, 10'(i % 4), '0, 1'b0);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    wait (s_axis_tready);
    @(negedge clk_i);
    test_directed();
    snd_idle = 11; rcv_idle = 72;
    set_config(6, 1'b0, 1'b0);
    test_random(120);
    set_config(3, 1'b1, 1'b1);
    test_random(120);
    snd_idle = 72; rcv_idle = 11;
    set_config(24'($urandom_range(1, 8)), 1'b1, 1'b0);
    test_random(120);
    set_config(24'($urandom), 1'b0, 1'b1);
    test_random(100);
    snd_idle = 0; rcv_idle = 0;
    test_holdoff();
    set_config(2, 1'b1, 1'b0);
    test_random(120);
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
design/srmv_pkg.sv
design/srmv_div.sv
design/srmv_ctrl.sv
design/srmv_dp.sv
design/sparse_row_mean_variance.sv
test/tb.sv
